// ===== hw/rtl/asidtlb_pkg.sv =====
// Shared types, field widths and request codes for the ASID allocator with
// TLB residency tracking. No dependencies; every module imports this package.
package asidtlb_pkg;

    localparam int DEF_NUM_CPUS = 4;
    localparam int DEF_NUM_IDS  = 256;

    localparam int REQ_W   = 2;
    localparam int ASID_W  = 32;
    localparam int ID_FW   = 8;
    localparam int GEN_W   = ASID_W - ID_FW;
    localparam int CPU_W   = 3;
    localparam int TABLE_W = 36;
    localparam int MGEN_W  = 32;
    localparam int CNT_W   = 64;

    // free-id search: groups of GRP_SIZE ids, one priority encoder per group
    localparam int GRP_SIZE  = 16;
    localparam int GRP_IDX_W = 4;

    localparam logic [REQ_W-1:0] REQ_ALLOC    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ACTIVATE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_PUBLISH  = 2'd3;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_CPU = 1'b1;

    localparam logic [GEN_W-1:0] GEN_FIRST = 24'd1;
    localparam logic [ID_FW-1:0] ID_FIRST  = 8'd1;

    typedef struct packed {
        logic [TABLE_W-1:0] table_page;
        logic [MGEN_W-1:0]  mgen;
    } res_lane_t;

    typedef struct packed {
        logic             rd;
        logic [ID_FW-1:0] rd_id;
        logic             set;
        logic             clear;
        logic             wipe;
        logic [ID_FW-1:0] wr_id;
        logic [GEN_W-1:0] wr_gen;
    } idmap_cmd_t;

    typedef struct packed {
        logic             hit;
        logic [ID_FW-1:0] free_id;
        logic [GEN_W-1:0] slot_gen;
    } idmap_stat_t;

    typedef struct packed {
        logic             rd;
        logic [ID_FW-1:0] rd_id;
        logic             wr;
        logic             clear;
        logic             wipe;
        logic [ID_FW-1:0] wr_id;
    } res_cmd_t;

endpackage

// ===== hw/rtl/asidtlb_id_map.sv =====
// Id map: in-use flags, slot generation memory and the two-stage free-id search.
// Depends on asidtlb_pkg.
module asidtlb_id_map #(
    parameter int NUM_IDS = asidtlb_pkg::DEF_NUM_IDS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  asidtlb_pkg::idmap_cmd_t  cmd,
    output asidtlb_pkg::idmap_stat_t stat
);
    import asidtlb_pkg::*;

    localparam int ID_W  = $clog2(NUM_IDS);
    localparam int NGRP  = (NUM_IDS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_W = NGRP * GRP_SIZE;

    logic [GEN_W-1:0]     gen_mem [NUM_IDS];
    logic [NUM_IDS-1:0]   in_use_reg;
    logic [GEN_W-1:0]     rd_gen_reg;
    logic                 rd_used_reg;
    logic [PAD_W-1:0]     used_pad;
    logic [PAD_W-1:0]     free_pad;
    logic [NGRP-1:0]      grp_any_next;
    logic [NGRP-1:0]      grp_any_reg;
    logic [GRP_IDX_W-1:0] grp_idx_next [NGRP];
    logic [GRP_IDX_W-1:0] grp_idx_reg  [NGRP];

    // wipe drops every id; a set in the same cycle still lands
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
        end
        else
        begin
            if (cmd.wipe)
            begin
                in_use_reg <= cmd.set ? (NUM_IDS'(1) << cmd.wr_id[ID_W-1:0]) : '0;
            end
            else if (cmd.clear)
            begin
                in_use_reg[cmd.wr_id[ID_W-1:0]] <= 1'b0;
            end
            else if (cmd.set)
            begin
                in_use_reg[cmd.wr_id[ID_W-1:0]] <= 1'b1;
            end
        end
    end

    // a free slot always reads generation zero, so the memory needs no clear
    always_ff @(posedge clk)
    begin
        if (cmd.set)
        begin
            gen_mem[cmd.wr_id[ID_W-1:0]] <= cmd.wr_gen;
        end
        if (cmd.rd)
        begin
            rd_gen_reg  <= gen_mem[cmd.rd_id[ID_W-1:0]];
            rd_used_reg <= in_use_reg[cmd.rd_id[ID_W-1:0]];
        end
    end

    always_comb
    begin
        used_pad                = '1;
        used_pad[NUM_IDS-1:0]   = in_use_reg;
        used_pad[0]             = 1'b1;
        free_pad                = ~used_pad;
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_any_next[g] = |free_pad[g*GRP_SIZE +: GRP_SIZE];
            grp_idx_next[g] = '0;
            for (int b = GRP_SIZE - 1; b >= 0; b--)
            begin
                if (free_pad[g*GRP_SIZE + b])
                begin
                    grp_idx_next[g] = GRP_IDX_W'(b);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_any_reg <= grp_any_next;
        grp_idx_reg <= grp_idx_next;
    end

    always_comb
    begin
        stat.hit      = 1'b0;
        stat.free_id  = '0;
        stat.slot_gen = rd_used_reg ? rd_gen_reg : '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                stat.hit     = 1'b1;
                stat.free_id = ID_FW'(g * GRP_SIZE) + ID_FW'(grp_idx_reg[g]);
            end
        end
    end

endmodule

// ===== hw/rtl/asidtlb_residency.sv =====
// Residency store: one row per id holding every CPU's table and mapping
// generation, with per-row valid flags. Depends on asidtlb_pkg.
module asidtlb_residency #(
    parameter int NUM_CPUS = asidtlb_pkg::DEF_NUM_CPUS,
    parameter int NUM_IDS  = asidtlb_pkg::DEF_NUM_IDS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  asidtlb_pkg::res_cmd_t                cmd,
    input  asidtlb_pkg::res_lane_t [NUM_CPUS-1:0] wr_row,
    output asidtlb_pkg::res_lane_t [NUM_CPUS-1:0] rd_row
);
    import asidtlb_pkg::*;

    localparam int ID_W = $clog2(NUM_IDS);

    res_lane_t [NUM_CPUS-1:0] row_mem [NUM_IDS];
    res_lane_t [NUM_CPUS-1:0] rd_row_reg;
    logic                     rd_valid_reg;
    logic [NUM_IDS-1:0]       row_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (cmd.wipe)
        begin
            row_valid_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                row_valid_reg[cmd.wr_id[ID_W-1:0]] <= 1'b0;
            end
            if (cmd.wr)
            begin
                row_valid_reg[cmd.wr_id[ID_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            row_mem[cmd.wr_id[ID_W-1:0]] <= wr_row;
        end
        if (cmd.rd)
        begin
            rd_row_reg   <= row_mem[cmd.rd_id[ID_W-1:0]];
            rd_valid_reg <= row_valid_reg[cmd.rd_id[ID_W-1:0]];
        end
    end

    // an invalid row reads as table zero, generation zero on every CPU
    assign rd_row = rd_valid_reg ? rd_row_reg : '0;

endmodule

// ===== hw/rtl/asid_allocator_tlb_residency.sv =====
// Top level of the ASID allocator with generation rollover and per-CPU TLB
// residency: request sequencer, generation and counters. Uses asidtlb_pkg,
// asidtlb_id_map and asidtlb_residency.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------------
//  request   | start in, busy out     | req_type, asid_in, cpu_id, table_page,
//            |                        | mapping_generation
//  result    | done out (one cycle)   | status, asid_out, rollover, flush_needed,
//            |                        | flush_total, preserve_total
//
// A transfer in takes place at a clock edge with start high and busy low.
// Busy then stays high while ST_LOOK reads the id map and the residency
// row and while ST_EXEC modifies and writes back. The result appears with
// done the cycle after ST_EXEC, when busy is already low, so a new request
// is taken only once the previous one has finished.
// Reset clears the in-use flags and row valid flags at once; there is no
// clearing pass. A rollover likewise drops all flags at once.
// The result receiver cannot stall: done is a one-cycle strobe.
module asid_allocator_tlb_residency #(
    parameter int NUM_CPUS = asidtlb_pkg::DEF_NUM_CPUS,
    parameter int NUM_IDS  = asidtlb_pkg::DEF_NUM_IDS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [asidtlb_pkg::REQ_W-1:0]     req_type,
    input  logic [asidtlb_pkg::ASID_W-1:0]    asid_in,
    input  logic [asidtlb_pkg::CPU_W-1:0]     cpu_id,
    input  logic [asidtlb_pkg::TABLE_W-1:0]   table_page,
    input  logic [asidtlb_pkg::MGEN_W-1:0]    mapping_generation,
    output logic                              done,
    output logic                              status,
    output logic [asidtlb_pkg::ASID_W-1:0]    asid_out,
    output logic                              rollover,
    output logic                              flush_needed,
    output logic [asidtlb_pkg::CNT_W-1:0]     flush_total,
    output logic [asidtlb_pkg::CNT_W-1:0]     preserve_total
);
    import asidtlb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    localparam logic [ID_FW:0] NUM_IDS_V  = (ID_FW + 1)'(NUM_IDS);
    localparam logic [CPU_W:0] NUM_CPUS_V = (CPU_W + 1)'(NUM_CPUS);

    logic [1:0]          state_reg, state_next;
    logic [REQ_W-1:0]    req_reg;
    logic [ASID_W-1:0]   asid_reg;
    logic [CPU_W-1:0]    cpu_reg;
    logic [TABLE_W-1:0]  table_reg;
    logic [MGEN_W-1:0]   mgen_reg;
    logic [GEN_W-1:0]    gen_reg, gen_next;
    logic [CNT_W-1:0]    flush_cnt_reg, flush_cnt_next;
    logic [CNT_W-1:0]    pres_cnt_reg, pres_cnt_next;
    logic                done_reg, done_next;
    logic                status_reg, status_next;
    logic [ASID_W-1:0]   asid_out_reg, asid_out_next;
    logic                roll_reg, roll_next;
    logic                flush_reg, flush_next;

    logic                accept;
    logic [ID_FW-1:0]    id_q;
    logic [GEN_W-1:0]    asid_gen_q;
    logic                id_ok;
    logic                cpu_ok;
    logic [GEN_W-1:0]    gen_inc;
    logic [GEN_W-1:0]    gen_bumped;
    logic                act_match;

    idmap_cmd_t               idm_cmd;
    idmap_stat_t              idm_stat;
    res_cmd_t                 res_cmd;
    res_lane_t [NUM_CPUS-1:0] res_row;
    res_lane_t [NUM_CPUS-1:0] act_row;
    res_lane_t [NUM_CPUS-1:0] pub_row;
    res_lane_t [NUM_CPUS-1:0] res_wr_row;

    asidtlb_id_map #(
        .NUM_IDS (NUM_IDS)
    ) u_id_map (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (idm_cmd),
        .stat  (idm_stat)
    );

    asidtlb_residency #(
        .NUM_CPUS (NUM_CPUS),
        .NUM_IDS  (NUM_IDS)
    ) u_residency (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (res_cmd),
        .wr_row (res_wr_row),
        .rd_row (res_row)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // hold the request fields for the whole transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            asid_reg  <= asid_in;
            cpu_reg   <= cpu_id;
            table_reg <= table_page;
            mgen_reg  <= mapping_generation;
        end
    end

    assign id_q       = asid_reg[ID_FW-1:0];
    assign asid_gen_q = asid_reg[ASID_W-1:ID_FW];
    assign id_ok      = ({1'b0, id_q} < NUM_IDS_V);
    assign cpu_ok     = ({1'b0, cpu_reg} < NUM_CPUS_V);

    // generation steps modulo 2^24 and skips zero
    assign gen_inc    = gen_reg + GEN_FIRST;
    assign gen_bumped = (gen_inc == '0) ? GEN_FIRST : gen_inc;

    // activate: compare the selected CPU's lane and build the refreshed row
    always_comb
    begin
        act_match = 1'b0;
        act_row   = res_row;
        for (int c = 0; c < NUM_CPUS; c++)
        begin
            if (CPU_W'(c) == cpu_reg)
            begin
                act_match = (res_row[c].table_page == table_reg) &&
                            (res_row[c].mgen == mgen_reg);
                act_row[c].table_page = table_reg;
                act_row[c].mgen       = mgen_reg;
            end
        end
    end

    // publish: refresh the generation on every CPU holding this table
    always_comb
    begin
        pub_row = res_row;
        for (int c = 0; c < NUM_CPUS; c++)
        begin
            if (res_row[c].table_page == table_reg)
            begin
                pub_row[c].mgen = mgen_reg;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        gen_next       = gen_reg;
        flush_cnt_next = flush_cnt_reg;
        pres_cnt_next  = pres_cnt_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        asid_out_next  = asid_out_reg;
        roll_next      = roll_reg;
        flush_next     = flush_reg;

        idm_cmd        = '0;
        idm_cmd.rd_id  = id_q;
        idm_cmd.wr_id  = id_q;
        idm_cmd.wr_gen = gen_reg;
        res_cmd        = '0;
        res_cmd.rd_id  = id_q;
        res_cmd.wr_id  = id_q;
        res_wr_row     = act_row;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                // issue the reads; an id beyond the tables reads nothing
                idm_cmd.rd = id_ok;
                res_cmd.rd = id_ok;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next    = ST_IDLE;
                done_next     = 1'b1;
                status_next   = STATUS_OK;
                asid_out_next = '0;
                roll_next     = 1'b0;
                flush_next    = 1'b0;
                case (req_reg)
                    REQ_ALLOC:
                    begin
                        if (idm_stat.hit)
                        begin
                            idm_cmd.set   = 1'b1;
                            idm_cmd.wr_id = idm_stat.free_id;
                            asid_out_next = {gen_reg, idm_stat.free_id};
                        end
                        else
                        begin
                            // rollover: drop every id and residency row, restart at id 1
                            idm_cmd.wipe   = 1'b1;
                            idm_cmd.set    = 1'b1;
                            idm_cmd.wr_id  = ID_FIRST;
                            idm_cmd.wr_gen = gen_bumped;
                            res_cmd.wipe   = 1'b1;
                            gen_next       = gen_bumped;
                            roll_next      = 1'b1;
                            asid_out_next  = {gen_bumped, ID_FIRST};
                        end
                    end
                    REQ_RELEASE:
                    begin
                        if ((id_q != '0) && id_ok && (idm_stat.slot_gen == asid_gen_q))
                        begin
                            idm_cmd.clear = 1'b1;
                            res_cmd.clear = 1'b1;
                        end
                    end
                    REQ_ACTIVATE:
                    begin
                        if (!cpu_ok)
                        begin
                            status_next = STATUS_BAD_CPU;
                        end
                        else if (!id_ok)
                        begin
                            flush_next     = 1'b1;
                            flush_cnt_next = flush_cnt_reg + CNT_W'(1);
                        end
                        else if (act_match)
                        begin
                            pres_cnt_next = pres_cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            res_cmd.wr     = 1'b1;
                            res_wr_row     = act_row;
                            flush_next     = 1'b1;
                            flush_cnt_next = flush_cnt_reg + CNT_W'(1);
                        end
                    end
                    REQ_PUBLISH:
                    begin
                        if (id_ok)
                        begin
                            res_cmd.wr = 1'b1;
                            res_wr_row = pub_row;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_reg       <= GEN_FIRST;
            flush_cnt_reg <= '0;
            pres_cnt_reg  <= '0;
            done_reg      <= 1'b0;
            status_reg    <= STATUS_OK;
            asid_out_reg  <= '0;
            roll_reg      <= 1'b0;
            flush_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            flush_cnt_reg <= flush_cnt_next;
            pres_cnt_reg  <= pres_cnt_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            asid_out_reg  <= asid_out_next;
            roll_reg      <= roll_next;
            flush_reg     <= flush_next;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign asid_out       = asid_out_reg;
    assign rollover       = roll_reg;
    assign flush_needed   = flush_reg;
    assign flush_total    = flush_cnt_reg;
    assign preserve_total = pres_cnt_reg;

endmodule
